>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

  // Address source for the permutation table port.
  typedef enum logic [2:0] {
    AD_I,
    AD_J,
    AD_I_NEXT,
    AD_J_NEXT,
    AD_KS
  } addr_sel_e;

  // Write data source for the permutation table port.
  typedef enum logic {
    WD_RD,
    WD_SI
  } wdata_sel_e;

  typedef enum logic [1:0] {
    J_HOLD,
    J_CLR,
    J_ADD,
    J_ADD_KEY
  } j_op_e;

  typedef enum logic [1:0] {
    I_HOLD,
    I_CLR,
    I_INC
  } i_op_e;

  typedef enum logic [1:0] {
    KI_HOLD,
    KI_CLR,
    KI_ADV
  } kidx_op_e;

  typedef enum logic [1:0] {
    BC_HOLD,
    BC_CLR,
    BC_INC
  } cnt_op_e;

  // Jump conditions: a step jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  typedef enum logic [2:0] {
    CD_NONE,
    CD_TRUE,
    CD_NO_IN,
    CD_DATA,
    CD_SCHED,
    CD_NOT_LAST,
    CD_LIMIT,
    CD_OUT_BUSY
  } cond_e;

  localparam int StepW = 5;
  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    logic       take;
    logic       perm_re;
    logic       perm_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wd_sel;
    logic       key_re;
    logic       ld_si;
    logic       ld_sj;
    i_op_e      i_op;
    j_op_e      j_op;
    kidx_op_e   kidx_op;
    cnt_op_e    cnt_op;
    logic       perm_clr;
    logic       sched_set;
    logic       key_op;
    logic       emit;
    cond_e      cond;
    step_t      target;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic is_data;
    logic sched;
    logic limit_hit;
    logic i_last;
    logic out_busy;
  } status_t;

endpackage

>>> hw/rtl/rc4_perm_ram.sv
module rc4_perm_ram import rc4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       re_i,
  input  logic       we_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o
);

  logic [7:0]   mem [256];
  logic [255:0] valid_q;
  logic [7:0]   rd_mem_q;
  logic [7:0]   rd_addr_q;
  logic         rd_vld_q;

  // An entry never written since the last clear reads as its own index,
  // which gives the identity permutation without a fill sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_mem_q  <= mem[addr_i];
      rd_addr_q <= addr_i;
      rd_vld_q  <= valid_q[addr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_mem_q : rd_addr_q;

endmodule

>>> hw/rtl/rc4_ucode_seq.sv
module rc4_ucode_seq import rc4_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam step_t StIdle = 5'd0;
  localparam step_t StDisp = 5'd1;
  localparam step_t StKey  = 5'd2;
  localparam step_t StData = 5'd3;
  localparam step_t StK0   = 5'd4;
  localparam step_t StK1   = 5'd5;
  localparam step_t StK2   = 5'd6;
  localparam step_t StK3   = 5'd7;
  localparam step_t StK4   = 5'd8;
  localparam step_t StKFin = 5'd9;
  localparam step_t StD0   = 5'd10;
  localparam step_t StD1   = 5'd11;
  localparam step_t StD2   = 5'd12;
  localparam step_t StD3   = 5'd13;
  localparam step_t StD4   = 5'd14;
  localparam step_t StD5   = 5'd15;
  localparam step_t StD6   = 5'd16;
  localparam step_t StD7   = 5'd17;

  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      StIdle: begin
        w.take   = 1'b1;
        w.cond   = CD_NO_IN;
        w.target = StIdle;
      end
      StDisp: begin
        w.cond   = CD_DATA;
        w.target = StData;
      end
      StKey: begin
        w.key_op = 1'b1;
        w.cond   = CD_TRUE;
        w.target = StIdle;
      end
      StData: begin
        w.cond   = CD_SCHED;
        w.target = StD0;
      end
      StK0: begin
        w.perm_clr = 1'b1;
        w.i_op     = I_CLR;
        w.j_op     = J_CLR;
        w.kidx_op  = KI_CLR;
        w.cnt_op   = BC_CLR;
      end
      StK1: begin
        w.perm_re  = 1'b1;
        w.addr_sel = AD_I;
        w.key_re   = 1'b1;
      end
      StK2: begin
        w.ld_si    = 1'b1;
        w.j_op     = J_ADD_KEY;
        w.perm_re  = 1'b1;
        w.addr_sel = AD_J_NEXT;
      end
      StK3: begin
        w.perm_we  = 1'b1;
        w.addr_sel = AD_I;
        w.wd_sel   = WD_RD;
      end
      StK4: begin
        w.perm_we  = 1'b1;
        w.addr_sel = AD_J;
        w.wd_sel   = WD_SI;
        w.i_op     = I_INC;
        w.kidx_op  = KI_ADV;
        w.cond     = CD_NOT_LAST;
        w.target   = StK1;
      end
      StKFin: begin
        w.j_op      = J_CLR;
        w.sched_set = 1'b1;
      end
      StD0: begin
        w.cond   = CD_LIMIT;
        w.target = StIdle;
      end
      StD1: begin
        w.i_op     = I_INC;
        w.perm_re  = 1'b1;
        w.addr_sel = AD_I_NEXT;
      end
      StD2: begin
        w.ld_si    = 1'b1;
        w.j_op     = J_ADD;
        w.perm_re  = 1'b1;
        w.addr_sel = AD_J_NEXT;
      end
      StD3: begin
        w.ld_sj    = 1'b1;
        w.perm_we  = 1'b1;
        w.addr_sel = AD_I;
        w.wd_sel   = WD_RD;
      end
      StD4: begin
        w.perm_we  = 1'b1;
        w.addr_sel = AD_J;
        w.wd_sel   = WD_SI;
      end
      StD5: begin
        w.perm_re  = 1'b1;
        w.addr_sel = AD_KS;
      end
      StD6: begin
        w.cond   = CD_OUT_BUSY;
        w.target = StD6;
      end
      StD7: begin
        w.emit   = 1'b1;
        w.cnt_op = BC_INC;
        w.cond   = CD_TRUE;
        w.target = StIdle;
      end
      default: begin
        w.cond   = CD_TRUE;
        w.target = StIdle;
      end
    endcase
    return w;
  endfunction

  step_t step_q, step_d;
  ctrl_t cw;
  logic  jump;

  always_comb begin
    cw = ucode_rom(step_q);
    case (cw.cond)
      CD_NONE:     jump = 1'b0;
      CD_TRUE:     jump = 1'b1;
      CD_NO_IN:    jump = !status_i.in_acc;
      CD_DATA:     jump = status_i.is_data;
      CD_SCHED:    jump = status_i.sched;
      CD_NOT_LAST: jump = !status_i.i_last;
      CD_LIMIT:    jump = status_i.limit_hit;
      CD_OUT_BUSY: jump = status_i.out_busy;
      default:     jump = 1'b0;
    endcase
    step_d = jump ? cw.target : step_t'(step_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;

endmodule

>>> hw/rtl/rc4_datapath.sv
module rc4_datapath import rc4_pkg::*; #(
  parameter int KEY_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic        in_valid_i,
  input  logic        action_i,
  input  logic [7:0]  value_i,
  input  logic [15:0] limit_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  cipher_byte_o,
  output logic [15:0] position_o,
  output status_t     status_o
);

  localparam logic [8:0] KeyMaxW = 9'(KEY_MAX);

  logic       act_q;
  logic [7:0] val_q;
  logic [7:0] i_q, j_q, si_q, sj_q, kidx_q;
  logic [8:0] key_len_q;
  logic       key_closed_q, sched_q;
  logic [15:0] cnt_q;
  logic       out_valid_q;
  logic [7:0] cipher_q;
  logic [15:0] pos_q;

  logic [7:0] key_mem [256];
  logic [7:0] key_rd_q;

  logic       in_acc;
  logic [7:0] perm_rd, perm_addr, perm_wd;
  logic [7:0] i_inc, kb, j_add, j_add_key, j_next;
  logic [8:0] len_eff;
  logic       closed_eff, key_we;

  assign in_acc = in_valid_i && ctrl_i.take;

  always_comb begin
    i_inc     = 8'(i_q + 8'd1);
    kb        = (key_len_q == 9'd0) ? 8'd0 : key_rd_q;
    j_add     = 8'(j_q + perm_rd);
    j_add_key = 8'(j_add + kb);
    j_next    = (ctrl_i.j_op == J_ADD_KEY) ? j_add_key : j_add;
    case (ctrl_i.addr_sel)
      AD_I:      perm_addr = i_q;
      AD_J:      perm_addr = j_q;
      AD_I_NEXT: perm_addr = i_inc;
      AD_J_NEXT: perm_addr = j_next;
      AD_KS:     perm_addr = 8'(si_q + sj_q);
      default:   perm_addr = i_q;
    endcase
    perm_wd = (ctrl_i.wd_sel == WD_SI) ? si_q : perm_rd;
  end

  // A key byte after a scheduled message starts a new key.
  always_comb begin
    len_eff    = sched_q ? 9'd0 : key_len_q;
    closed_eff = sched_q ? 1'b0 : key_closed_q;
    key_we     = ctrl_i.key_op && !closed_eff && (val_q != 8'd0) && (len_eff < KeyMaxW);
  end

  function automatic logic [7:0] i_q_wrap(logic [7:0] v);
    return 8'(v + 8'd1);
  endfunction

  rc4_perm_ram u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctrl_i.perm_clr),
    .re_i    (ctrl_i.perm_re),
    .we_i    (ctrl_i.perm_we),
    .addr_i  (perm_addr),
    .wdata_i (perm_wd),
    .rdata_o (perm_rd)
  );

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[len_eff[7:0]] <= val_q;
    end
    if (ctrl_i.key_re) begin
      key_rd_q <= key_mem[kidx_q];
    end
    if (in_acc) begin
      act_q <= action_i;
      val_q <= value_i;
    end
    if (ctrl_i.ld_si) begin
      si_q <= perm_rd;
    end
    if (ctrl_i.ld_sj) begin
      sj_q <= perm_rd;
    end
    if (ctrl_i.emit) begin
      cipher_q <= val_q ^ perm_rd;
      pos_q    <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q          <= '0;
      j_q          <= '0;
      kidx_q       <= '0;
      key_len_q    <= '0;
      key_closed_q <= 1'b0;
      sched_q      <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      case (ctrl_i.i_op)
        I_CLR:   i_q <= '0;
        I_INC:   i_q <= i_inc;
        default: i_q <= i_q;
      endcase
      case (ctrl_i.j_op)
        J_CLR:     j_q <= '0;
        J_ADD:     j_q <= j_add;
        J_ADD_KEY: j_q <= j_add_key;
        default:   j_q <= j_q;
      endcase
      case (ctrl_i.kidx_op)
        KI_CLR: kidx_q <= '0;
        KI_ADV: kidx_q <= (({1'b0, kidx_q} + 9'd1) == key_len_q) ? 8'd0 : i_q_wrap(kidx_q);
        default: kidx_q <= kidx_q;
      endcase
      case (ctrl_i.cnt_op)
        BC_CLR:  cnt_q <= '0;
        BC_INC:  cnt_q <= 16'(cnt_q + 16'd1);
        default: cnt_q <= cnt_q;
      endcase
      if (ctrl_i.key_op) begin
        sched_q      <= 1'b0;
        key_len_q    <= key_we ? 9'(len_eff + 9'd1) : len_eff;
        key_closed_q <= closed_eff || (val_q == 8'd0);
      end else if (ctrl_i.sched_set) begin
        sched_q <= 1'b1;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.in_acc    = in_acc;
    status_o.is_data   = act_q;
    status_o.sched     = sched_q;
    status_o.limit_hit = (cnt_q >= limit_i);
    status_o.i_last    = (i_q == 8'hFF);
    status_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;
  assign position_o    = pos_q;

endmodule

>>> hw/rtl/rc4_stream_cipher_core.sv
// Key byte transaction: accepted in the idle step; StDisp and StKey follow, then idle again.
// Data byte transaction: result registered in StD7; the next byte is taken back in idle;
// the first data byte of a message adds a key schedule (StK1 to StK4 for each table entry).
// A data byte past the output limit gives no result; StD0 sends the program back to idle.
// Rate is set by the single-port permutation table: two reads, two writes, one read per byte.
// Reset (rst_ni low, asynchronous) clears control, indices, key length and table valid bits.
module rc4_stream_cipher_core import rc4_pkg::*; #(
  parameter int KEY_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cipher_byte_o,
  output logic [15:0] position_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // The output limit register. Writes are taken at any time; the user only
  // changes it while the block is idle.
  logic [15:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // The sequencer steps through a fixed control program. Each control word
  // selects the table address, the write data and which registers load, and
  // carries a conditional jump. The datapath reports the conditions back.
  ctrl_t   cw;
  status_t st;

  rc4_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (st),
    .ctrl_o   (cw)
  );

  // The output register parts the two sides: a new transaction is taken as
  // soon as the program returns to its idle step, even while the previous
  // result still waits downstream.
  rc4_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (cw),
    .in_valid_i    (in_valid_i),
    .action_i      (action_i),
    .value_i       (value_i),
    .limit_i       (limit_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .cipher_byte_o (cipher_byte_o),
    .position_o    (position_o),
    .status_o      (st)
  );

  assign in_stall_o = !cw.take;

`ifndef SYNTHESIS
  // A new result never overwrites one that is still stalled downstream.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw.emit |-> !st.out_busy)
    else $error("result emitted while output register is held");

  // After a transaction is accepted, the block is busy on the next cycle.
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // The permutation table has one port: never read and write together.
  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cw.perm_we && cw.perm_re))
    else $error("permutation table read and written in one cycle");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the RC4 stream cipher core.
//
// The input channel carries key bytes and data bytes. A scoreboard object keeps its
// own copy of the cipher state (permutation table, key store, indices, byte count
// and output limit). For every accepted input transaction it predicts whether a
// result comes out and, if so, which cipher byte and position it carries. Every
// accepted output transaction is compared with the oldest prediction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Input action codes.
  localparam bit ActKey  = 1'b0;
  localparam bit ActData = 1'b1;

  localparam int KeyMax = 256;

  // The first data byte of a message runs a whole key schedule. When the output limit
  // stops that byte, no result marks the end of the work, so every wait for an idle
  // block covers a whole schedule and some margin.
  localparam int SettleCycles = 1100;

  // The slowest correct run stays far below this bound.
  localparam int CycleLimit = 1000000;

  localparam int ItemsPerPhase = 45;
  localparam int NumPhases = 6;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0]  cipher_byte;
    logic [15:0] position;
  } cipher_result_t;

  // Scoreboard: predicts the cipher output and checks what the block returns.
  class cipher_tracker;
    bit [7:0]       perm [256];
    bit [7:0]       key_bytes [256];
    bit [8:0]       key_len;
    bit             key_closed;
    bit [7:0]       idx_i;
    bit [7:0]       idx_j;
    bit             scheduled;
    bit [15:0]      byte_count;
    bit [15:0]      out_limit;
    cipher_result_t cipher_q [$];
    int             mismatches;
    int             results_seen;

    function new();
      for (int n = 0; n < 256; n++) begin
        perm[n] = n[7:0];
        key_bytes[n] = 8'h00;
      end
      key_len = '0;
      key_closed = 1'b0;
      idx_i = '0;
      idx_j = '0;
      scheduled = 1'b0;
      byte_count = '0;
      out_limit = 16'hFFFF;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_limit(bit [15:0] limit);
      out_limit = limit;
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction

    // Key scheduling: start from the identity permutation and mix in the key.
    // An empty key behaves as a single zero byte.
    function void run_key_schedule();
      bit [7:0] acc;
      bit [7:0] kb;
      bit [7:0] tmp;
      acc = '0;
      for (int n = 0; n < 256; n++) begin
        perm[n] = n[7:0];
      end
      for (int n = 0; n < 256; n++) begin
        kb = (key_len != 0) ? key_bytes[n % key_len] : 8'h00;
        acc = acc + perm[n] + kb;
        tmp = perm[n];
        perm[n] = perm[acc];
        perm[acc] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
      byte_count = '0;
      scheduled = 1'b1;
    endfunction

    function void note_input(bit act, bit [7:0] val);
      bit [7:0] tmp;
      bit [7:0] ks_addr;
      cipher_result_t res;
      if (act == ActKey) begin
        // A key byte after data begins a new message.
        if (scheduled) begin
          key_len = '0;
          key_closed = 1'b0;
          scheduled = 1'b0;
        end
        if (key_closed) begin
          return;
        end
        if (val == 8'h00) begin
          key_closed = 1'b1;
        end else if (key_len < KeyMax) begin
          key_bytes[key_len[7:0]] = val;
          key_len = key_len + 1'b1;
        end
        return;
      end
      if (!scheduled) begin
        run_key_schedule();
      end
      if (byte_count >= out_limit) begin
        return;
      end
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + perm[idx_i];
      tmp = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      ks_addr = perm[idx_i] + perm[idx_j];
      res.cipher_byte = val ^ perm[ks_addr];
      res.position = byte_count;
      cipher_q.push_back(res);
      byte_count = byte_count + 1'b1;
    endfunction

    function void check_result(bit [7:0] cipher_byte, bit [15:0] position);
      cipher_result_t exp_res;
      results_seen++;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: unexpected result cipher_byte=%02h position=%0d",
                   cipher_byte, position);
        end
        return;
      end
      exp_res = cipher_q.pop_front();
      if (exp_res.cipher_byte !== cipher_byte || exp_res.position !== position) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: result %0d expected cipher_byte=%02h position=%0d, got %02h %0d",
                   results_seen, exp_res.cipher_byte, exp_res.position,
                   cipher_byte, position);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  value = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  cipher_byte;
  logic [15:0] position;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  cipher_tracker tracker;

  // Percentage of cycles in which the sender idles and the receiver stalls. One
  // phase runs with both at zero so that the block also sees back-to-back traffic.
  int idle_pct = 29;
  int items_sent = 0;
  int messages = 0;
  int cycles = 0;

  rc4_stream_cipher_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cipher_byte_o(cipher_byte),
    .position_o   (position),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls at random. Everything is sampled at the rising edge, so the
  // monitor sees the stall value that the block saw at the same edge.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Output monitor: a transaction completes when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(cipher_byte, position);
    end
  end

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  // Drives one input transaction. Valid stays high after acceptance so that the
  // next transaction can follow without a gap; it drops for idle cycles and in wait_idle.
  task automatic send_item(input bit act, input logic [7:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    value <= val;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    tracker.note_input(act, val);
  endtask

  // Waits until every predicted result has arrived and the block has had time to
  // finish a key schedule that produced no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] limit);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_limit(limit);
  endtask

  // One message: a key followed by data bytes. A small share of calls sends noise
  // instead, i.e. random key and data bytes in any order.
  task automatic send_message(input bit long_key);
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        send_item(1'($urandom_range(1)), rand_byte());
      end
      items_sent += n;
      return;
    end
    if (long_key) begin
      // Overfill the key store; bytes past its capacity are dropped.
      n = KeyMax + $urandom_range(1, 24);
      for (int k = 0; k < n; k++) begin
        send_item(ActKey, 8'($urandom_range(1, 255)));
      end
      items_sent += n;
    end else if (kind < 18) begin
      // An empty key, sometimes with a key byte after the terminator.
      send_item(ActKey, 8'h00);
      items_sent++;
      if (kind < 14) begin
        send_item(ActKey, rand_byte());
        items_sent++;
      end
    end else begin
      n = $urandom_range(1, 16);
      for (int k = 0; k < n; k++) begin
        send_item(ActKey, 8'($urandom_range(1, 255)));
      end
      items_sent += n;
      if ($urandom_range(1)) begin
        // Zero terminator, then key bytes that must be ignored.
        send_item(ActKey, 8'h00);
        items_sent++;
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
          send_item(ActKey, rand_byte());
        end
        items_sent += n;
      end
    end
    n = $urandom_range(1, 14);
    for (int k = 0; k < n; k++) begin
      send_item(ActData, rand_byte());
    end
    items_sent += n;
    messages++;
  endtask

  initial begin
    logic [15:0] phase_limits [NumPhases];
    int target;
    bit first;

    tracker = new();
    phase_limits[0] = 16'd0;
    phase_limits[1] = 16'd1;
    phase_limits[2] = 16'd3;
    phase_limits[3] = 16'($urandom_range(2, 12));
    phase_limits[4] = 16'hFFFF;
    phase_limits[5] = 16'd7;

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    write_limit(16'hFFFF);

    // Directed part. Data before any key uses an empty key.
    send_item(ActData, 8'h00);
    send_item(ActData, 8'hFF);
    // A short key ended by a zero byte; the key byte after it is ignored.
    send_item(ActKey, 8'h01);
    send_item(ActKey, 8'h80);
    send_item(ActKey, 8'hFF);
    send_item(ActKey, 8'h00);
    send_item(ActKey, 8'h7F);
    send_item(ActData, 8'hFF);
    send_item(ActData, 8'h00);
    send_item(ActData, 8'h5A);
    // A key made only of its terminator behaves as an empty key.
    send_item(ActKey, 8'h00);
    send_item(ActKey, 8'hAA);
    send_item(ActData, 8'h01);
    send_item(ActData, 8'hFE);
    items_sent = 14;
    messages = 3;

    // Random phases, each under a different output limit. Phase 4 runs without
    // idling or stalls; phases 1 and 3 begin with an overfilled key.
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(phase_limits[p]);
      idle_pct = (p == 4) ? 0 : 29;
      target = items_sent + ItemsPerPhase;
      first = 1'b1;
      while (items_sent < target) begin
        send_message(first && (p == 1 || p == 3));
        first = 1'b0;
      end
    end
    idle_pct = 29;

    wait_idle();

    $display("Sent %0d input transactions in %0d messages under %0d output limits.",
             items_sent, messages, NumPhases + 1);
    $display("Checked %0d cipher results, %0d mismatching.",
             tracker.results_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
